FILE: src/assert_macros.svh
// Assertion macros shared by the set store RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/uas_pkg.sv
// Types, codes and defaults for the unordered array set store.
// Used by every module of the block but uas_ram; depends on nothing.
`default_nettype none

package uas_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PosW        = 5;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [ValueW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic            was_present;
    logic [PosW-1:0] position;
    logic [PosW-1:0] count_after;
    logic [1:0]      status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic search;
    logic decide;
    logic move;
    logic emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/uas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module uas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/uas_dp.sv
// Datapath: value store, search pointer, operation result and output register.
// Depends on uas_pkg, uas_ram and assert_macros.svh.
`default_nettype none

module uas_dp #(
  parameter int unsigned CAPACITY = uas_pkg::CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire uas_pkg::ctrl_cmd_t cmd_i,
  output uas_pkg::dp_stat_t       stat_o,
  input  wire uas_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output uas_pkg::out_item_t      out_item_o
);
  import uas_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [ValueW-1:0] key_q, key_d;
  logic [1:0]        act_q, act_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [1:0]        status_q, status_d;
  logic              move_q, move_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic             more;
  logic             hit;
  logic             rd_go;
  logic             scan_end;
  logic             out_free;
  logic [CNT_W-1:0] last;

  uas_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // read issued one cycle, compared the next
  assign more     = rd_idx_q < count_q;
  assign hit      = pend_q && (ram_rdata == key_q);
  assign rd_go    = cmd_i.search && more && !hit;
  assign scan_end = !pend_q && !more;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = count_q - 1'b1;

  assign stat_o.search_done = hit || scan_end;
  assign stat_o.out_free    = out_free;

  always_comb begin
    key_d       = key_q;
    act_d       = act_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    cmp_idx_d   = rd_idx_q[IDX_W-1:0];
    found_d     = found_q;
    pos_d       = pos_q;
    status_d    = status_q;
    move_d      = move_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IDX_W-1:0];
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IDX_W-1:0];

    if (cmd_i.load) begin
      key_d    = in_item_i.item_value;
      act_d    = in_item_i.action;
      rd_idx_d = '0;
    end

    if (cmd_i.search) begin
      pend_d = rd_go;
      ram_re = rd_go;
      if (rd_go) begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
      if (hit) begin
        found_d = 1'b1;
        pos_d   = CNT_W'(cmp_idx_q);
      end else if (scan_end) begin
        found_d = 1'b0;
        pos_d   = count_q;
      end
    end

    if (cmd_i.decide) begin
      move_d   = 1'b0;
      status_d = ST_DONE;
      case (act_q)
        ACT_INSERT: begin
          if (found_q) begin
            status_d = ST_DUPLICATE;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        ACT_DELETE: begin
          if (found_q) begin
            // fetch the last entry; it fills the hole on the next cycle
            move_d    = pos_q != last;
            ram_re    = 1'b1;
            ram_raddr = last[IDX_W-1:0];
            count_d   = last;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end

    if (cmd_i.move && move_q) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end

    if (cmd_i.emit) begin
      out_valid_d             = 1'b1;
      out_item_d.was_present  = found_q;
      out_item_d.position     = PosW'(pos_q);
      out_item_d.count_after  = PosW'(count_q);
      out_item_d.status       = status_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    act_q      <= act_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    status_q   <= status_d;
    move_q     <= move_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`include "assert_macros.svh"

  `ASSERT_CHK(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `ASSERT_CHK(a_scan_bound, clk_i, rst_ni, !cmd_i.search || rd_idx_q <= count_q)
  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_valid_q)

endmodule

`default_nettype wire

FILE: src/uas_ctrl.sv
// Controller: sequences accept, search, update, move and result steps.
// Depends on uas_pkg and assert_macros.svh.
`default_nettype none

module uas_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire uas_pkg::dp_stat_t stat_i,
  output uas_pkg::ctrl_cmd_t     cmd_o
);
  import uas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_MOVE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SEARCH;
      S_SEARCH: if (stat_i.search_done) state_d = S_DECIDE;
      S_DECIDE: state_d = S_MOVE;
      S_MOVE:   state_d = S_RESULT;
      S_RESULT: if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= state_d != S_IDLE;
    end
  end

  assign in_stall_o   = stall_q;
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i && !stall_q;
  assign cmd_o.search = state_q == S_SEARCH;
  assign cmd_o.decide = state_q == S_DECIDE;
  assign cmd_o.move   = state_q == S_MOVE;
  assign cmd_o.emit   = (state_q == S_RESULT) && stat_i.out_free;

`include "assert_macros.svh"

  `ASSERT_CHK(a_stall_idle, clk_i, rst_ni, stall_q == (state_q != S_IDLE))
  `ASSERT_NEXT(a_accept_search, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_SEARCH)

endmodule

`default_nettype wire

FILE: src/unordered_array_set_store.sv
// Unordered array set store: up to CAPACITY distinct signed 32-bit values
// kept unordered in a RAM, with lookup, insert and delete.
// Input channel: in_valid_i / in_stall_o with in_item_i (action, item_value);
// a transfer happens when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with out_item_o (was_present,
// position, count_after, status), one result per input item.
// One item is handled at a time. The linear search reads one entry per cycle
// through the single RAM read port, and a miss closes the scan in a further
// step after the last compare. Then come the update, move and result steps.
// The next transfer can be taken in the cycle after the result is loaded.
// in_stall_o stays high from the transfer until the result is loaded.
// The result register holds while out_stall_i is high; a new item can be
// accepted while it waits, and its result is loaded once the register frees.
// Reset empties the set (count zero); RAM contents are not cleared and are
// only read below the count.
// Depends on uas_pkg, uas_ctrl, uas_dp and uas_ram.
`default_nettype none

module unordered_array_set_store #(
  parameter int unsigned CAPACITY = uas_pkg::CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire uas_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output uas_pkg::out_item_t      out_item_o
);
  import uas_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  uas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  uas_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: verif/unordered_array_set_store_tb.sv
// Self-checking testbench for unordered_array_set_store: directed table, then random set traffic.
// Results are checked against an in-bench set predictor. Depends on uas_pkg and the RTL only.
`timescale 1ns / 1ps

module unordered_array_set_store_tb;
  import uas_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned RandItems  = 850;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned DrainWait  = 40;
  localparam logic signed [ValueW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValMax = 32'sh7fff_ffff;
  // unused action code, behaves as lookup
  localparam logic [1:0] ActUnused = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  unordered_array_set_store #(
    .CAPACITY(CapacityDef)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the set
  logic signed [ValueW-1:0] set_vals [CapacityDef];
  int unsigned              set_cnt;

  out_item_t   pending_results [$];
  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned status_seen [4];
  int unsigned peak_cnt;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];
  logic signed [ValueW-1:0] value_pool [PoolSize];

  function automatic out_item_t mk_res(logic wp, int unsigned pos, int unsigned cnt,
                                       logic [1:0] st);
    out_item_t r;
    r.was_present = wp;
    r.position    = PosW'(pos);
    r.count_after = PosW'(cnt);
    r.status      = st;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] act, logic signed [ValueW-1:0] val);
    in_item_t it;
    it.action     = act;
    it.item_value = val;
    return it;
  endfunction

  function automatic void add_row(logic [1:0] act, logic signed [ValueW-1:0] val,
                                  bit typed, out_item_t want);
    dir_row_t row;
    row.stim  = mk_item(act, val);
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Applies one operation to the predicted set and returns its result.
  function automatic out_item_t apply_set_op(in_item_t it);
    int unsigned slot;
    int unsigned cnt_prev;
    logic        hit;
    logic [1:0]  st;
    cnt_prev = set_cnt;
    slot     = cnt_prev;
    st       = ST_DONE;
    for (int i = 0; i < cnt_prev; i++)
      if (set_vals[i] == it.item_value) slot = i;
    hit = (slot < cnt_prev);
    if (it.action == ACT_INSERT) begin
      if (hit) begin
        st = ST_DUPLICATE;
      end else if (cnt_prev >= CapacityDef) begin
        st = ST_FULL;
      end else begin
        set_vals[cnt_prev] = it.item_value;
        set_cnt = cnt_prev + 1;
      end
    end else if (it.action == ACT_DELETE) begin
      if (hit) begin
        // last entry fills the hole
        set_vals[slot] = set_vals[cnt_prev-1];
        set_cnt = cnt_prev - 1;
      end else begin
        st = ST_NOT_FOUND;
      end
    end
    return mk_res(hit, slot, set_cnt, st);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned gap;
    out_item_t   pred;
    gap = ((sent_cnt / 40) % 4 == 1) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_set_op(it);
    pending_results.push_back(typed ? want : pred);
    status_seen[pred.status]++;
    if (set_cnt > peak_cnt) peak_cnt = set_cnt;
    sent_cnt++;
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (set_cnt > 0 && r < 45) return set_vals[$urandom_range(0, set_cnt - 1)];
    if (r < 75) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $signed($urandom);
  endfunction

  function automatic logic [1:0] pick_action(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 95) return ActUnused;
    if (grow) begin
      if (r < 55) return ACT_INSERT;
      if (r < 75) return ACT_DELETE;
    end else begin
      if (r < 20) return ACT_INSERT;
      if (r < 60) return ACT_DELETE;
    end
    return ACT_LOOKUP;
  endfunction

  // receiver: random hold before each transfer, with stall-free stretches
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned hold;
      hold = ((checked_cnt / 48) % 3 == 0) ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_item_t want;
      checked_cnt++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("[%0d] result with nothing pending: %p", cycle_cnt, out_item_o);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.was_present !== want.was_present ||
            out_item_o.position    !== want.position    ||
            out_item_o.count_after !== want.count_after ||
            out_item_o.status      !== want.status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0d] result %0d mismatch: exp %p got %p",
                     cycle_cnt, checked_cnt, want, out_item_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("FAIL unordered_array_set_store");
      $finish;
    end
  end

  initial begin
    out_item_t none;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    sent_cnt   = 0;
    checked_cnt = 0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    peak_cnt   = 0;
    set_cnt    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    none = '0;

    value_pool[0] = ValMin;
    value_pool[1] = ValMax;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $signed($urandom);

    // empty store, extremes, duplicate, unused code, fill to capacity
    add_row(ACT_LOOKUP, 0,      1'b1, mk_res(1'b0, 0, 0, ST_DONE));
    add_row(ACT_DELETE, 5,      1'b1, mk_res(1'b0, 0, 0, ST_NOT_FOUND));
    add_row(ACT_INSERT, ValMin, 1'b1, mk_res(1'b0, 0, 1, ST_DONE));
    add_row(ACT_INSERT, ValMax, 1'b1, mk_res(1'b0, 1, 2, ST_DONE));
    add_row(ACT_INSERT, ValMin, 1'b1, mk_res(1'b1, 0, 2, ST_DUPLICATE));
    add_row(ACT_LOOKUP, ValMax, 1'b1, mk_res(1'b1, 1, 2, ST_DONE));
    add_row(ActUnused,  -1,     1'b1, mk_res(1'b0, 2, 2, ST_DONE));
    for (int k = 0; k < CapacityDef - 2; k++)
      add_row(ACT_INSERT, 32'sd37 * k - 32'sd3, 1'b0, none);
    add_row(ACT_INSERT, 32'sd12345, 1'b1, mk_res(1'b0, 16, 16, ST_FULL));
    // last entry dropped, then first entry refilled from the tail
    add_row(ACT_DELETE, 32'sd37 * (CapacityDef - 3) - 32'sd3, 1'b0, none);
    add_row(ACT_DELETE, ValMin, 1'b0, none);
    add_row(ACT_LOOKUP, 32'sd37 * (CapacityDef - 4) - 32'sd3, 1'b0, none);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RandItems; n++) begin
      logic [1:0] act;
      act = pick_action((n / 60) % 2 == 0);
      send_item(mk_item(act, pick_value()), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, peak occupancy %0d of %0d",
             sent_cnt, checked_cnt, peak_cnt, CapacityDef);
    $display("done %0d, duplicate inserts %0d, full refusals %0d, absent deletes %0d",
             status_seen[ST_DONE], status_seen[ST_DUPLICATE],
             status_seen[ST_FULL], status_seen[ST_NOT_FOUND]);
    if (err_cnt == 0) begin
      $display("PASS unordered_array_set_store");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL unordered_array_set_store");
    end
    $finish;
  end

endmodule
